// ===== sv/ss_pkg.sv =====
`timescale 1ns / 1ps
package ss_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int MW = 36;
    localparam int PW = 2 * MW;

    localparam logic signed [MW-1:0] HALF_PI = 36'sd1686629713;
    localparam logic [15:0] DRIVE_ONE = 16'd8192;
    localparam logic [15:0] DRIVE_TWO = 16'd16384;
    localparam logic [15:0] UNITY_Q15 = 16'd32768;
    localparam logic [24:0] UNITY_Q24 = 25'd16777216;

    localparam logic [2:0] CFG_DRIVE  = 3'd0;
    localparam logic [2:0] CFG_COEFF  = 3'd1;
    localparam logic [2:0] CFG_GAIN   = 3'd2;
    localparam logic [2:0] CFG_WET    = 3'd3;

    typedef struct packed {
        logic [15:0] drive;
        logic [24:0] coeff;
        logic [15:0] dry_share;
        logic [30:0] gain_wet;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic ack;
    } t_ctl;

    typedef struct packed {
        logic done;
    } t_stat;

    // series divisors: sine 6,20,42,72,110 then cosine 12,30,56,90
    function automatic logic [6:0] div_of(input logic [3:0] idx);
        logic [6:0] d;
        case (idx)
            4'd0: d = 7'd6;
            4'd1: d = 7'd20;
            4'd2: d = 7'd42;
            4'd3: d = 7'd72;
            4'd4: d = 7'd110;
            4'd5: d = 7'd12;
            4'd6: d = 7'd30;
            4'd7: d = 7'd56;
            4'd8: d = 7'd90;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^36 / divisor)
    function automatic logic [MW-1:0] recip_of(input logic [3:0] idx);
        logic [MW-1:0] r;
        case (idx)
            4'd0: r = MW'((64'd1 << 36) / 64'd6);
            4'd1: r = MW'((64'd1 << 36) / 64'd20);
            4'd2: r = MW'((64'd1 << 36) / 64'd42);
            4'd3: r = MW'((64'd1 << 36) / 64'd72);
            4'd4: r = MW'((64'd1 << 36) / 64'd110);
            4'd5: r = MW'((64'd1 << 36) / 64'd12);
            4'd6: r = MW'((64'd1 << 36) / 64'd30);
            4'd7: r = MW'((64'd1 << 36) / 64'd56);
            4'd8: r = MW'((64'd1 << 36) / 64'd90);
            default: r = MW'((64'd1 << 36) / 64'd6);
        endcase
        return r;
    endfunction

endpackage

// ===== sv/ss_lane.sv =====
`timescale 1ns / 1ps
module ss_lane #(
    parameter int SAMPLE_WIDTH = ss_pkg::SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ss_pkg::t_ctl                   i_ctl,
    input  ss_pkg::t_cfg                   i_cfg,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output ss_pkg::t_stat                  o_stat,
    output logic signed [SAMPLE_WIDTH-1:0] o_out
);

    localparam int MW = ss_pkg::MW;
    localparam int PW = ss_pkg::PW;
    localparam int OSH = 61 - SAMPLE_WIDTH;

    typedef enum logic [21:0] {
        S_IDLE = 22'h000001, S_LP   = 22'h000002, S_LPW  = 22'h000004,
        S_H    = 22'h000008, S_T    = 22'h000010, S_TC   = 22'h000020,
        S_U    = 22'h000040, S_UC   = 22'h000080, S_XM   = 22'h000100,
        S_XS   = 22'h000200, S_TM   = 22'h000400, S_TD   = 22'h000800,
        S_TR   = 22'h001000, S_TQ   = 22'h002000, S_SF   = 22'h004000,
        S_Y1   = 22'h008000, S_Y2   = 22'h010000, S_Y3   = 22'h020000,
        S_M0   = 22'h040000, S_M1   = 22'h080000, S_M2   = 22'h100000,
        S_DONE = 22'h200000
    } t_state;

    t_state r_state;
    logic signed [31:0] r_x31, r_lp;
    logic signed [MW-1:0] r_h, r_term, r_x, r_sum, r_n, r_y;
    logic signed [PW-1:0] r_p, r_acc;
    logic r_neg, r_cos;
    logic [2:0] r_k;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    logic signed [MW-1:0] mul_a, mul_b, c_h;
    logic signed [PW-1:0] w_prod;
    logic signed [MW-1:0] w_diff;
    logic [15:0] m_abs;
    logic [3:0] div_idx;
    logic [6:0] div_c;

    always_comb begin
        w_diff = MW'(r_x31) - ((i_cfg.coeff == '0) ? '0 : MW'(r_lp));
        m_abs = (i_cfg.drive > ss_pkg::DRIVE_ONE) ? i_cfg.drive - ss_pkg::DRIVE_ONE
                                                  : ss_pkg::DRIVE_ONE - i_cfg.drive;
        if (r_h > (MW'(1) <<< 30)) begin
            c_h = MW'(1) <<< 30;
        end else if (r_h < -(MW'(1) <<< 30)) begin
            c_h = -(MW'(1) <<< 30);
        end else begin
            c_h = r_h;
        end
        div_idx = r_cos ? 4'(r_k) + 4'd5 : 4'(r_k);
        div_c = ss_pkg::div_of(div_idx);
    end

    // one shared multiplier, operands picked by step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_LP: begin mul_a = w_diff; mul_b = MW'(i_cfg.coeff); end
            S_T:  begin mul_a = r_h; mul_b = MW'(i_cfg.drive); end
            S_U:  begin mul_a = r_term; mul_b = ss_pkg::HALF_PI; end
            S_XM: begin
                mul_a = r_cos ? r_h : r_term;
                mul_b = r_cos ? c_h : r_term;
            end
            S_TM: begin mul_a = r_term; mul_b = r_x; end
            S_TR: begin mul_a = r_n; mul_b = ss_pkg::recip_of(div_idx); end
            S_Y1: begin mul_a = r_h; mul_b = MW'(ss_pkg::DRIVE_ONE - m_abs); end
            S_Y2: begin mul_a = r_sum; mul_b = MW'(m_abs); end
            S_M0: begin mul_a = MW'(r_x31); mul_b = MW'(i_cfg.dry_share); end
            S_M1: begin mul_a = r_y; mul_b = MW'(i_cfg.gain_wet); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign w_prod = mul_a * mul_b;

    logic signed [PW-1:0] v13, v30, v30b, v31, sumf, osh;
    logic signed [MW-1:0] q0, qv, qs, rem_v, lim;
    logic last_term;

    always_comb begin
        v13 = r_p >>> 13;
        v30 = r_p >>> 30;
        v31 = r_p >>> 31;
        v30b = r_acc + r_p;
        sumf = v30b >>> 13;
        osh = v30b >>> OSH;
        q0 = MW'(r_p >>> 36);
        rem_v = r_n - q0 * MW'(div_c);
        qv = (rem_v >= MW'(div_c)) ? q0 + MW'(1) : q0;
        qs = r_neg ? -qv : qv;
        last_term = r_cos ? (r_k == 3'd3) : (r_k == 3'd4);
        lim = MW'(1) <<< (SAMPLE_WIDTH - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lp <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_x31 <= 32'(i_sample) <<< (32 - SAMPLE_WIDTH);
                        r_state <= S_LP;
                    end
                end
                S_LP: begin
                    r_p <= w_prod;
                    r_state <= S_LPW;
                end
                S_LPW: begin
                    r_lp <= (i_cfg.coeff == '0) ? '0 : r_lp + 32'(r_p >>> 24);
                    r_state <= S_H;
                end
                S_H: begin
                    r_h <= (MW'(r_x31) - MW'(r_lp)) >>> 1;
                    r_cos <= (i_cfg.drive < ss_pkg::DRIVE_ONE);
                    if (i_cfg.drive > ss_pkg::DRIVE_ONE) begin
                        r_state <= S_T;
                    end else if (i_cfg.drive < ss_pkg::DRIVE_ONE) begin
                        r_state <= S_XM;
                    end else begin
                        r_sum <= (MW'(r_x31) - MW'(r_lp)) >>> 1;
                        r_state <= S_SF;
                    end
                end
                S_T: begin
                    r_p <= w_prod;
                    r_state <= S_TC;
                end
                S_TC: begin
                    if (v13 > (PW'(1) <<< 31)) begin
                        r_term <= MW'(1) <<< 31;
                    end else if (v13 < -(PW'(1) <<< 31)) begin
                        r_term <= -(MW'(1) <<< 31);
                    end else begin
                        r_term <= MW'(v13);
                    end
                    r_state <= S_U;
                end
                S_U: begin
                    r_p <= w_prod;
                    r_state <= S_UC;
                end
                S_UC: begin
                    if (v30 > PW'(ss_pkg::HALF_PI)) begin
                        r_term <= ss_pkg::HALF_PI;
                        r_sum <= ss_pkg::HALF_PI;
                    end else if (v30 < -PW'(ss_pkg::HALF_PI)) begin
                        r_term <= -ss_pkg::HALF_PI;
                        r_sum <= -ss_pkg::HALF_PI;
                    end else begin
                        r_term <= MW'(v30);
                        r_sum <= MW'(v30);
                    end
                    r_state <= S_XM;
                end
                S_XM: begin
                    r_p <= w_prod;
                    r_state <= S_XS;
                end
                S_XS: begin
                    r_x <= MW'(v30);
                    if (r_cos) begin
                        r_term <= MW'(v31);
                        r_sum <= MW'(v31);
                    end
                    r_k <= '0;
                    r_state <= S_TM;
                end
                S_TM: begin
                    r_p <= w_prod;
                    r_state <= S_TD;
                end
                S_TD: begin
                    r_neg <= v30 < 0;
                    r_n <= (v30 < 0) ? -MW'(v30) : MW'(v30);
                    r_state <= S_TR;
                end
                S_TR: begin
                    r_p <= w_prod;
                    r_state <= S_TQ;
                end
                S_TQ: begin
                    // terms alternate, starting with a subtraction
                    r_term <= qs;
                    r_sum <= r_k[0] ? r_sum + qs : r_sum - qs;
                    r_k <= r_k + 3'd1;
                    r_state <= last_term ? S_SF : S_TM;
                end
                S_SF: begin
                    if (r_cos && r_h < 0) begin
                        r_sum <= -r_sum;
                        r_y <= -r_sum;
                    end else begin
                        r_y <= r_sum;
                    end
                    r_state <= (i_cfg.drive > ss_pkg::DRIVE_TWO) ? S_M0 : S_Y1;
                end
                S_Y1: begin
                    r_p <= w_prod;
                    r_state <= S_Y2;
                end
                S_Y2: begin
                    r_acc <= r_p;
                    r_p <= w_prod;
                    r_state <= S_Y3;
                end
                S_Y3: begin
                    r_y <= MW'(sumf);
                    r_state <= S_M0;
                end
                S_M0: begin
                    r_p <= w_prod;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_acc <= r_p <<< 14;
                    r_p <= w_prod;
                    r_state <= S_M2;
                end
                S_M2: begin
                    if (osh > PW'(lim - MW'(1))) begin
                        r_out <= SAMPLE_WIDTH'(lim - MW'(1));
                    end else if (osh < -PW'(lim)) begin
                        r_out <= SAMPLE_WIDTH'(-lim);
                    end else begin
                        r_out <= SAMPLE_WIDTH'(osh);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_ctl.ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.done = (r_state == S_DONE);
    assign o_out = r_out;

endmodule

// ===== sv/stereo_sine_saturator.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// in      | input     | i_in_valid/o_in_stall | i_left_sample, i_right_sample
// out     | output    | o_out_valid/i_out_stall | o_left_out, o_right_out
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// one request at a time: each lane steps its shared multiplier through the
// lowpass, shaping series (skipped at unity drive) and mix, with four steps
// per series term (multiply, divide)
// reset clears the lowpass state and restores the default registers
// a finished pair waits in the output register while the next request runs
module stereo_sine_saturator #(
    parameter int SAMPLE_WIDTH = ss_pkg::SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_left_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_right_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [2:0]                     i_cfg_index,
    input  logic [24:0]                    i_cfg_data
);

    logic [15:0] r_drive, r_gain, r_wet;
    logic [24:0] r_coeff;
    logic [30:0] r_gw;
    logic r_busy, r_ov;
    logic signed [SAMPLE_WIDTH-1:0] r_left, r_right;

    ss_pkg::t_cfg cfg;
    ss_pkg::t_ctl ctl;
    ss_pkg::t_stat st_l, st_r;
    logic signed [SAMPLE_WIDTH-1:0] out_l, out_r;
    logic accept, merge;
    logic [15:0] g_sat, w_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= ss_pkg::DRIVE_ONE;
            r_coeff <= '0;
            r_gain <= ss_pkg::UNITY_Q15;
            r_wet <= ss_pkg::UNITY_Q15;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ss_pkg::CFG_DRIVE: r_drive <= i_cfg_data[15:0];
                ss_pkg::CFG_COEFF: r_coeff <= i_cfg_data;
                ss_pkg::CFG_GAIN:  r_gain <= i_cfg_data[15:0];
                ss_pkg::CFG_WET:   r_wet <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign g_sat = (r_gain > ss_pkg::UNITY_Q15) ? ss_pkg::UNITY_Q15 : r_gain;
    assign w_sat = (r_wet > ss_pkg::UNITY_Q15) ? ss_pkg::UNITY_Q15 : r_wet;

    always_ff @(posedge i_clk) begin
        r_gw <= 31'(g_sat) * 31'(w_sat);
    end

    assign cfg.drive = r_drive;
    assign cfg.coeff = (r_coeff > ss_pkg::UNITY_Q24) ? ss_pkg::UNITY_Q24 : r_coeff;
    assign cfg.dry_share = ss_pkg::UNITY_Q15 - w_sat;
    assign cfg.gain_wet = r_gw;

    assign o_in_stall = r_busy;
    assign accept = i_in_valid && !r_busy;
    assign merge = st_l.done && st_r.done && (!r_ov || !i_out_stall);
    assign ctl.start = accept;
    assign ctl.ack = merge;

    ss_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_cfg(cfg),
        .i_sample(i_left_sample), .o_stat(st_l), .o_out(out_l)
    );

    ss_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_cfg(cfg),
        .i_sample(i_right_sample), .o_stat(st_r), .o_out(out_r)
    );

    // merge both lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (merge) begin
                r_busy <= 1'b0;
            end
            if (merge) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (merge) begin
            r_left <= out_l;
            r_right <= out_r;
        end
    end

    assign o_out_valid = r_ov;
    assign o_left_out = r_left;
    assign o_right_out = r_right;

endmodule

// ===== sv/ss_checker.sv =====
`timescale 1ns / 1ps
module ss_checker #(
    parameter int SAMPLE_WIDTH = ss_pkg::SAMPLE_WIDTH
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [SAMPLE_WIDTH-1:0] o_left_out,
    input logic [SAMPLE_WIDTH-1:0] o_right_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_left_out) && $stable(o_right_out)))
        else $error("stalled output changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled while a request is at work");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset left a request pending");

endmodule

bind stereo_sine_saturator ss_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ss_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
    .o_left_out(o_left_out), .o_right_out(o_right_out)
);
